// ===== design/sfp_pkg.sv =====
// Package for the serial frame parser: result kind codes, register map,
// and the header set handed from the register block to the parser core.
// No dependencies.
package sfp_pkg;

   // Register file layout.
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrIdxWidth  = 2;

   // Frame trailer value expected in the last byte of a frame.
   localparam logic [7:0] EndMark = 8'h00;

   // Register indexes (byte address / 4).
   typedef enum logic [CsrIdxWidth-1:0] {
      REG_HEADER_A = 2'd0,
      REG_HEADER_B = 2'd1,
      REG_HEADER_C = 2'd2
   } reg_index_type;

   // Kind code carried with every echoed byte.
   typedef enum logic [2:0] {
      KIND_IGNORED = 3'd0,
      KIND_HEADER  = 3'd1,
      KIND_LENGTH  = 3'd2,
      KIND_BODY    = 3'd3,
      KIND_GOOD    = 3'd4,
      KIND_BAD     = 3'd5,
      KIND_ABORT   = 3'd6
   } kind_type;

   // The three configured frame-start byte values.
   typedef struct packed {
      logic [7:0] header_a;
      logic [7:0] header_b;
      logic [7:0] header_c;
   } header_set_type;

endpackage

// ===== design/sfp_csr.sv =====
// APB-style register block of the serial frame parser.
// Holds the three header registers; depends on sfp_pkg.
module sfp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sfp_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [sfp_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [sfp_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready,
   output sfp_pkg::header_set_type             headers
);
   import sfp_pkg::*;

   header_set_type headers_ff;
   header_set_type headers_in;
   reg_index_type  reg_index;
   logic           write_en;

   // The access phase of a write never waits; csr_pready is tied high.
   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode the write into the addressed header register.
   always_comb begin
      headers_in = headers_ff;
      if (write_en) begin
         case (reg_index)
            REG_HEADER_A: headers_in.header_a = csr_pwdata[7:0];
            REG_HEADER_B: headers_in.header_b = csr_pwdata[7:0];
            REG_HEADER_C: headers_in.header_c = csr_pwdata[7:0];
            default:      headers_in = headers_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         headers_ff <= '0;
      end else begin
         headers_ff <= headers_in;
      end
   end

   // Read mux; the unused slot reads as zero.
   always_comb begin
      case (reg_index)
         REG_HEADER_A: csr_prdata = {{(CsrDataWidth-8){1'b0}}, headers_ff.header_a};
         REG_HEADER_B: csr_prdata = {{(CsrDataWidth-8){1'b0}}, headers_ff.header_b};
         REG_HEADER_C: csr_prdata = {{(CsrDataWidth-8){1'b0}}, headers_ff.header_c};
         default:      csr_prdata = '0;
      endcase
   end

   assign headers = headers_ff;

endmodule

// ===== design/sfp_core.sv =====
// Parser core of the serial frame parser: frame state, running XOR check
// and the result register. Depends on sfp_pkg.
module sfp_core (
   input  logic                        clock,
   input  logic                        reset,
   input  sfp_pkg::header_set_type     headers,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_kind,
   output logic [7:0]                  rsp_echo_byte,
   output logic [7:0]                  rsp_position
);
   import sfp_pkg::*;

   // Frame state.
   logic       in_frame_ff, in_frame_in;
   logic       have_length_ff, have_length_in;
   logic [7:0] byte_count_ff, byte_count_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] running_check_ff, running_check_in;
   logic [7:0] previous_byte_ff, previous_byte_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   kind_ff, kind_in;
   logic [7:0] echo_byte_ff;
   logic [7:0] position_ff, position_in;

   logic       accept;
   logic       is_header;
   logic [8:0] next_pos;
   logic [9:0] next_pos_wide;
   logic [9:0] length_wide;

   // A new beat enters whenever the result register is empty or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_header = (req_rx_byte == headers.header_a) ||
                      (req_rx_byte == headers.header_b) ||
                      (req_rx_byte == headers.header_c);
   assign next_pos      = {1'b0, byte_count_ff} + 9'd1;
   assign next_pos_wide = {1'b0, next_pos};
   assign length_wide   = {2'b00, frame_length_ff};

   // Next frame state and the result for the byte on the input.
   always_comb begin
      in_frame_in      = in_frame_ff;
      have_length_in   = have_length_ff;
      byte_count_in    = byte_count_ff;
      frame_length_in  = frame_length_ff;
      running_check_in = running_check_ff;
      previous_byte_in = req_rx_byte;
      kind_in          = KIND_IGNORED;
      position_in      = 8'd0;

      if (!in_frame_ff) begin
         // Hunting for a header byte.
         if (is_header) begin
            in_frame_in      = 1'b1;
            have_length_in   = 1'b0;
            byte_count_in    = 8'd1;
            running_check_in = req_rx_byte;
            kind_in          = KIND_HEADER;
            position_in      = 8'd1;
         end
      end else if (!have_length_ff) begin
         // Second byte is the frame length.
         byte_count_in    = 8'd2;
         have_length_in   = 1'b1;
         frame_length_in  = req_rx_byte;
         running_check_in = running_check_ff ^ req_rx_byte;
         kind_in          = KIND_LENGTH;
         position_in      = 8'd2;
      end else begin
         // Body bytes: the check covers positions up to length-2 and is
         // inverted at length-1; the comparisons stay unsigned by moving
         // the offsets to the position side.
         position_in = next_pos[7:0];
         kind_in     = KIND_BODY;
         if (next_pos_wide + 10'd2 <= length_wide) begin
            running_check_in = running_check_ff ^ req_rx_byte;
         end
         if (next_pos_wide + 10'd1 == length_wide) begin
            running_check_in = ~running_check_ff;
         end
         if (next_pos_wide == length_wide) begin
            kind_in       = ((previous_byte_ff == running_check_ff) &&
                             (req_rx_byte == EndMark)) ? KIND_GOOD : KIND_BAD;
            in_frame_in   = 1'b0;
            byte_count_in = 8'd0;
         end else if (next_pos_wide > length_wide) begin
            kind_in       = KIND_ABORT;
            in_frame_in   = 1'b0;
            byte_count_in = 8'd0;
         end else begin
            byte_count_in = next_pos[7:0];
         end
      end
   end

   // Result register valid: set by an accepted beat, cleared when taken.
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff      <= 1'b0;
         have_length_ff   <= 1'b0;
         byte_count_ff    <= 8'd0;
         frame_length_ff  <= 8'd0;
         running_check_ff <= 8'd0;
         previous_byte_ff <= 8'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_frame_ff      <= in_frame_in;
            have_length_ff   <= have_length_in;
            byte_count_ff    <= byte_count_in;
            frame_length_ff  <= frame_length_in;
            running_check_ff <= running_check_in;
            previous_byte_ff <= previous_byte_in;
         end
      end
   end

   // Result payload, loaded with each accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= kind_in;
         echo_byte_ff <= req_rx_byte;
         position_ff  <= position_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_echo_byte = echo_byte_ff;
   assign rsp_position  = position_ff;

endmodule

// ===== design/serial_frame_parser.sv =====
// Serial frame parser top level: register block and parser core.
// Depends on sfp_pkg, sfp_csr and sfp_core.
//
//   Port group  Direction  Carries
//   req_*       in         one received byte per beat (req_rx_byte)
//   rsp_*       out        kind, echoed byte and frame position per beat
//   csr_*       in/out     header_a/b/c registers at byte offsets 0, 4, 8
//
// Each taken byte beat produces exactly one result beat in the next cycle.
// The parser accepts one byte every cycle unless a result is held in the
// single result register while rsp_ready is low. Reset is synchronous and
// clears the frame state, the result valid flag and the header registers.
// The user must write header registers only while idle; it is not enforced.
module serial_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_kind,
   output logic [7:0]                          rsp_echo_byte,
   output logic [7:0]                          rsp_position,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sfp_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [sfp_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [sfp_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import sfp_pkg::*;

   header_set_type headers;

   // Configuration registers.
   sfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .headers     (headers)
   );

   // Frame parsing and result register.
   sfp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .headers       (headers),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_echo_byte (rsp_echo_byte),
      .rsp_position  (rsp_position)
   );

endmodule

// ===== design/sfp_checker.sv =====
// Port-level checks for the serial frame parser, bound to the top level.
// Depends on sfp_pkg and serial_frame_parser.
module sfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_rx_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_echo_byte,
   input logic [7:0] rsp_position
);
   import sfp_pkg::*;

   // A pending result holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte))
      else $error("result dropped or changed while stalled");

   // Every accepted byte is echoed in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && rsp_echo_byte == $past(req_rx_byte))
      else $error("accepted byte not echoed on the next cycle");

   // Fixed positions for the ignored, header and length kinds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind != KIND_IGNORED || rsp_position == 8'd0) &&
                    (rsp_kind != KIND_HEADER  || rsp_position == 8'd1) &&
                    (rsp_kind != KIND_LENGTH  || rsp_position == 8'd2))
      else $error("position does not match kind");

   // Frame ends and body bytes sit beyond the length byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_BODY || rsp_kind == KIND_GOOD ||
                    rsp_kind == KIND_BAD || rsp_kind == KIND_ABORT)
      |-> rsp_position >= 8'd3)
      else $error("body or frame end at a header position");

endmodule

bind serial_frame_parser sfp_checker u_sfp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_rx_byte   (req_rx_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_kind      (rsp_kind),
   .rsp_echo_byte (rsp_echo_byte),
   .rsp_position  (rsp_position)
);

// ===== tb/tb.sv =====
// Testbench for serial_frame_parser: random and directed byte streams with a frame predictor.
// Depends on sfp_pkg and the serial_frame_parser RTL. The headers are set over the csr_ port.
// Every result beat is checked in order against the predicted kind, echoed byte and position.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfp_pkg::*;

   localparam int PhaseItems = 130;
   localparam int CycleLimit = 400000;
   localparam int MaxPrinted = 40;

   // One predicted result beat.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] echo_byte;
      logic [7:0] position;
   } byte_result_type;

   // Ways a generated frame can be spoiled.
   typedef enum int {FLAW_NONE, FLAW_CHECK, FLAW_TRAILER} frame_flaw_type;

   // Frame parser predictor and the queue of expected result beats.
   class frame_scoreboard;
      logic [7:0]      headers [3];
      bit              in_frame;
      bit              have_length;
      logic [7:0]      byte_count;
      logic [7:0]      frame_length;
      logic [7:0]      running_check;
      logic [7:0]      previous_byte;
      byte_result_type expected_q [$];
      int              mismatches;
      int              results_seen;
      int              kind_seen [7];

      function new();
         foreach (headers[i]) headers[i] = 8'h00;
         foreach (kind_seen[i]) kind_seen[i] = 0;
         in_frame = 1'b0;
         have_length = 1'b0;
         byte_count = 8'h00;
         frame_length = 8'h00;
         running_check = 8'h00;
         previous_byte = 8'h00;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void set_header(reg_index_type idx, logic [7:0] value);
         headers[idx] = value;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
      endtask

      // Work out the result beat for one accepted byte and update the frame state.
      function void note_byte(logic [7:0] rx);
         byte_result_type want;
         int nxt;
         int len;
         want.kind = KIND_IGNORED;
         want.echo_byte = rx;
         want.position = 8'd0;
         if (!in_frame) begin
            if (rx == headers[0] || rx == headers[1] || rx == headers[2]) begin
               in_frame = 1'b1;
               have_length = 1'b0;
               byte_count = 8'd1;
               running_check = rx;
               want.kind = KIND_HEADER;
               want.position = 8'd1;
            end
         end else if (!have_length) begin
            byte_count = 8'd2;
            have_length = 1'b1;
            frame_length = rx;
            running_check = running_check ^ rx;
            want.kind = KIND_LENGTH;
            want.position = 8'd2;
         end else begin
            nxt = int'(byte_count) + 1;
            len = int'(frame_length);
            want.position = nxt[7:0];
            want.kind = KIND_BODY;
            if (nxt <= len - 2) running_check = running_check ^ rx;
            if (nxt == len - 1) running_check = ~running_check;
            if (nxt == len) begin
               want.kind = (previous_byte == running_check && rx == EndMark) ?
                           KIND_GOOD : KIND_BAD;
               in_frame = 1'b0;
               byte_count = 8'd0;
            end else if (nxt > len) begin
               want.kind = KIND_ABORT;
               in_frame = 1'b0;
               byte_count = 8'd0;
            end else begin
               byte_count = nxt[7:0];
            end
         end
         previous_byte = rx;
         expected_q.push_back(want);
      endfunction

      // Compare one accepted result beat with the oldest prediction.
      task check_result(logic [2:0] kind, logic [7:0] echo_byte, logic [7:0] position);
         byte_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result kind %0d byte %02h with no byte pending",
                                      kind, echo_byte));
            return;
         end
         want = expected_q.pop_front();
         results_seen++;
         kind_seen[want.kind]++;
         if (kind !== want.kind)
            report_mismatch($sformatf("byte %02h: kind %0d, expected %0d",
                                      want.echo_byte, kind, want.kind));
         if (echo_byte !== want.echo_byte)
            report_mismatch($sformatf("echo byte %02h, expected %02h",
                                      echo_byte, want.echo_byte));
         if (position !== want.position)
            report_mismatch($sformatf("byte %02h: position %0d, expected %0d",
                                      want.echo_byte, position, want.position));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_echo_byte;
   logic [7:0]  rsp_position;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic        csr_pready;

   frame_scoreboard sb = new();
   logic [7:0]  header_copy [3];
   bit          sender_gaps;
   bit          receiver_gaps;
   int          stall_left;
   int          bytes_sent;
   int          cycle_count;

   serial_frame_parser i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_echo_byte (rsp_echo_byte),
      .rsp_position  (rsp_position),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #6 clock = ~clock;

   // Abort the run if it hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("tb NOT OK");
         $finish;
      end
   end

   // Result side: random stall bursts while enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (receiver_gaps && !reset && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(1, 11) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Every accepted result beat goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_kind, rsp_echo_byte, rsp_position);
   end

   // Write one header register, then read it back.
   task automatic write_header(reg_index_type idx, logic [7:0] value);
      logic [CsrDataWidth-1:0] rd;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_header(idx, value);
      header_copy[idx] = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (rd[7:0] !== value)
         sb.report_mismatch($sformatf("header register %0d reads %02h, wrote %02h",
                                      idx, rd[7:0], value));
   endtask

   task automatic configure(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
      write_header(REG_HEADER_A, a);
      write_header(REG_HEADER_B, b);
      write_header(REG_HEADER_C, c);
   endtask

   // Offer one byte beat, with an optional idle burst ahead of it.
   task automatic send_byte(logic [7:0] value);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(value);
      bytes_sent++;
   endtask

   // Header, length, body, check byte and trailer; the flaw spoils one of the last two.
   task automatic send_frame(logic [7:0] hdr, logic [7:0] len, frame_flaw_type flaw);
      logic [7:0] check;
      logic [7:0] data;
      int p;
      check = hdr ^ len;
      send_byte(hdr);
      send_byte(len);
      if (len < 8'd3) begin
         // The third byte already lies past the length.
         send_byte(8'($urandom));
      end else if (len == 8'd3) begin
         send_byte(flaw == FLAW_NONE ? EndMark : 8'($urandom_range(1, 255)));
      end else begin
         for (p = 3; p <= int'(len) - 2; p++) begin
            data = 8'($urandom);
            check = check ^ data;
            send_byte(data);
         end
         data = ~check;
         if (flaw == FLAW_CHECK) data = data ^ 8'($urandom_range(1, 255));
         send_byte(data);
         send_byte(flaw == FLAW_TRAILER ? 8'($urandom_range(1, 255)) : EndMark);
      end
   endtask

   // Mostly well-formed frames, some spoiled or short ones, some loose bytes.
   task automatic send_random_item();
      int pick;
      logic [7:0] hdr;
      logic [7:0] len;
      pick = $urandom_range(0, 99);
      hdr = header_copy[$urandom_range(0, 2)];
      if (pick < 10) begin
         send_byte(8'($urandom));
      end else if (pick < 95) begin
         len = ($urandom_range(0, 59) == 0) ? 8'($urandom_range(13, 255))
                                            : 8'($urandom_range(4, 12));
         send_frame(hdr, len, pick < 80 ? FLAW_NONE : pick < 88 ? FLAW_CHECK : FLAW_TRAILER);
      end else begin
         send_frame(hdr, 8'($urandom_range(0, 3)), FLAW_NONE);
      end
   endtask

   task automatic run_random(int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_random_item();
   endtask

   // Hold the sender off until every predicted beat has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: loose bytes, good and bad frames, short lengths.
      configure(8'hA5, 8'h3C, 8'hFF);
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
      send_byte(8'h00);
      send_byte(8'h55);
      send_frame(8'hA5, 8'd5, FLAW_NONE);
      send_frame(8'h3C, 8'd4, FLAW_CHECK);
      send_frame(8'hFF, 8'd4, FLAW_TRAILER);
      send_frame(8'hA5, 8'd3, FLAW_NONE);
      send_frame(8'h3C, 8'd0, FLAW_NONE);
      send_frame(8'hFF, 8'd2, FLAW_NONE);
      run_random(PhaseItems);
      wait_for_results();

      // All headers zero: a length-three frame can pass only with a zero header.
      configure(8'h00, 8'h00, 8'h00);
      send_frame(8'h00, 8'd3, FLAW_NONE);
      run_random(PhaseItems);
      wait_for_results();

      configure(8'hFF, 8'h80, 8'h01);
      run_random(PhaseItems);
      wait_for_results();

      configure(8'($urandom), 8'($urandom), 8'($urandom));
      run_random(PhaseItems);
      wait_for_results();

      // Last part: no idling on either side, duplicated header, longest frame.
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      begin
         logic [7:0] dup;
         dup = 8'($urandom);
         configure(dup, dup, 8'($urandom));
      end
      send_frame(header_copy[0], 8'd255, FLAW_NONE);
      run_random(PhaseItems);
      wait_for_results();
      repeat (8) @(posedge clock);

      if (sb.expected_q.size() != 0)
         sb.report_mismatch($sformatf("%0d result beats never arrived", sb.expected_q.size()));
      $display("Ran %0d byte beats and checked %0d result beats under five header settings.",
               bytes_sent, sb.results_seen);
      $display("Frames seen: %0d good, %0d bad, %0d aborted; %0d bytes ignored while hunting.",
               sb.kind_seen[KIND_GOOD], sb.kind_seen[KIND_BAD], sb.kind_seen[KIND_ABORT],
               sb.kind_seen[KIND_IGNORED]);
      if (sb.mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

// ===== serial_frame_parser.f =====
design/sfp_pkg.sv
design/sfp_csr.sv
design/sfp_core.sv
design/serial_frame_parser.sv
design/sfp_checker.sv
tb/tb.sv
